[sv/rtf_lz_window_decompressor_macros.svh]
// Assertion macros for the compressed RTF window decompressor.
`ifndef RTF_LZ_WINDOW_DECOMPRESSOR_MACROS_SVH
`define RTF_LZ_WINDOW_DECOMPRESSOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RTFLZ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rtflz assertion failed");
`define RTFLZ_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtflz implication failed");
`define RTFLZ_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtflz next-cycle check failed");
`else
`define RTFLZ_ASSERT(lbl, clk, rst_n, prop)
`define RTFLZ_IMPLY(lbl, clk, rst_n, ante, cons)
`define RTFLZ_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/rtflz_pkg.sv]
// Package: constants, types and preamble table of the RTF window decompressor.
`timescale 1ns / 1ps
package rtflz_pkg;

    localparam int WINDOW_DEPTH    = 4096;
    localparam int WIN_AW          = $clog2(WINDOW_DEPTH);
    localparam int PREAMBLE_LENGTH = 207;

    localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;
    localparam logic [4:0] MIN_MATCH       = 5'd2;

    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_REF   = 2'd2;

    typedef logic [WIN_AW-1:0] win_addr_t;
    typedef logic [WIN_AW:0]   win_fill_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } seq_state_t;

    typedef struct packed {
        logic      rd_en;
        win_addr_t rd_addr;
        logic      wr_en;
        logic [7:0] wr_data;
    } win_req_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       done;
    } emit_t;

    // first character in the top byte
    localparam logic [8*PREAMBLE_LENGTH-1:0] PREAMBLE_BITS = {
        "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}{\\f0\\fnil \\froman ",
        "\\fswiss \\fmodern \\fscript \\fdecor MS Sans SerifSymbolArialTimes ",
        "New RomanCourier{\\colortbl\\red0\\green0\\blue0",
        8'h0D, 8'h0A,
        "\\par \\pard",
        "\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
    };

    function automatic logic [7:0] preamble_byte(input win_addr_t addr);
        int         bitpos;
        logic [7:0] b;
        bitpos = 0;
        b      = '0;
        if (int'(addr) < PREAMBLE_LENGTH)
        begin
            bitpos = 8 * (PREAMBLE_LENGTH - 1 - int'(addr));
            b      = PREAMBLE_BITS[bitpos +: 8];
        end
        return b;
    endfunction

endpackage

[sv/rtflz_ifs.sv]
// Channel interfaces: compressed input, decompressed output, configuration.
`timescale 1ns / 1ps
interface rtflz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface rtflz_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    modport source (output valid, output out_byte, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_done,
                    output ready);
endinterface

interface rtflz_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_length;
    modport source (output valid, output target_length, input ready);
    modport sink   (input valid, input target_length, output ready);
endinterface

[sv/rtflz_window.sv]
// History window: 4096-byte memory, write pointer, fill count and preamble default.
`timescale 1ns / 1ps
module rtflz_window (
    input  logic                clk,
    input  logic                rst_n,
    input  rtflz_pkg::win_req_t req,
    output logic [7:0]          rdata
);
    import rtflz_pkg::*;

    localparam win_addr_t PRE_START  = win_addr_t'(PREAMBLE_LENGTH);
    localparam win_fill_t FILL_LIMIT = win_fill_t'(WINDOW_DEPTH);

    logic [7:0] mem [WINDOW_DEPTH];
    win_addr_t  wpos_reg, wpos_next;
    win_fill_t  fill_reg, fill_next;
    logic [7:0] mem_q, dflt_q;
    logic       hit_q;
    logic       hit;
    win_addr_t  rel_addr;

    // entries are written in order from the preamble end; fill counts them
    always_comb
    begin
        rel_addr  = req.rd_addr - PRE_START;
        hit       = {1'b0, rel_addr} < fill_reg;
        wpos_next = wpos_reg;
        fill_next = fill_reg;
        if (req.wr_en)
        begin
            wpos_next = wpos_reg + 1'b1;
            if (fill_reg != FILL_LIMIT)
                fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= PRE_START;
            fill_reg <= '0;
        end
        else
        begin
            wpos_reg <= wpos_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[wpos_reg] <= req.wr_data;
        if (req.rd_en)
        begin
            mem_q  <= mem[req.rd_addr];
            dflt_q <= preamble_byte(req.rd_addr);
            hit_q  <= hit;
        end
    end

    assign rdata = hit_q ? mem_q : dflt_q;

endmodule

[sv/rtflz_seq.sv]
// Sequencer: flag/token parsing, byte-at-a-time copy loop and output count.
`timescale 1ns / 1ps
`include "rtf_lz_window_decompressor_macros.svh"
module rtflz_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_data,
    input  logic                slot_free,
    output rtflz_pkg::emit_t    emit,
    output rtflz_pkg::win_req_t win_req,
    input  logic [7:0]          win_rdata
);
    import rtflz_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  tokens_reg, tokens_next;
    logic [7:0]  ref_hi_reg, ref_hi_next;
    logic [31:0] produced_reg, produced_next;
    logic [31:0] target_reg;
    logic        finished_reg, finished_next;
    logic [7:0]  lit_reg, lit_next;
    logic        use_lit_reg, use_lit_next;
    win_addr_t   pos_reg, pos_next;
    logic [4:0]  len_reg, len_next;

    logic        accept;
    logic        active;
    logic [31:0] sum;
    logic        hit_done;
    logic [3:0]  tok_dec;

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        accept   = in_valid && in_ready;
        active   = !finished_reg && (produced_reg < target_reg);
        sum      = produced_reg + 32'd1;
        hit_done = (sum >= target_reg);
        tok_dec  = (tokens_reg == 4'd0) ? 4'd0 : tokens_reg - 4'd1;

        emit.valid = (state_reg == S_EMIT) && slot_free;
        emit.data  = use_lit_reg ? lit_reg : win_rdata;
        emit.done  = hit_done;
        emit.last  = hit_done || (len_reg == 5'd1);

        win_req.rd_en   = (state_reg == S_READ);
        win_req.rd_addr = pos_reg;
        win_req.wr_en   = emit.valid;
        win_req.wr_data = emit.data;

        state_next    = state_reg;
        phase_next    = phase_reg;
        flag_next     = flag_reg;
        tokens_next   = tokens_reg;
        ref_hi_next   = ref_hi_reg;
        produced_next = produced_reg;
        finished_next = finished_reg;
        lit_next      = lit_reg;
        use_lit_next  = use_lit_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && active)
                begin
                    case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (!flag_reg[0])
                            begin
                                lit_next     = in_byte;
                                use_lit_next = 1'b1;
                                len_next     = 5'd1;
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                ref_hi_next = in_byte;
                                phase_next  = PH_REF;
                            end
                        end
                        PH_REF:
                        begin
                            pos_next     = {ref_hi_reg, in_byte[7:4]};
                            len_next     = {1'b0, in_byte[3:0]} + MIN_MATCH;
                            use_lit_next = 1'b0;
                            state_next   = S_READ;
                        end
                        default:
                        begin
                            flag_next   = in_byte;
                            tokens_next = TOKENS_PER_FLAG;
                            phase_next  = PH_TOKEN;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    produced_next = sum;
                    if (hit_done)
                        finished_next = 1'b1;
                    if (emit.last)
                    begin
                        flag_next   = flag_reg >> 1;
                        tokens_next = tok_dec;
                        phase_next  = (tok_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        len_next   = len_reg - 5'd1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_FLAG;
            flag_reg     <= '0;
            tokens_reg   <= '0;
            ref_hi_reg   <= '0;
            produced_reg <= '0;
            finished_reg <= 1'b0;
            target_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            flag_reg     <= flag_next;
            tokens_reg   <= tokens_next;
            ref_hi_reg   <= ref_hi_next;
            produced_reg <= produced_next;
            finished_reg <= finished_next;
            if (cfg_valid)
                target_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg     <= lit_next;
        use_lit_reg <= use_lit_next;
        pos_reg     <= pos_next;
        len_reg     <= len_next;
    end

    `RTFLZ_IMPLY(a_emit_below_target, clk, rst_n, emit.valid, produced_reg < target_reg)
    `RTFLZ_IMPLY(a_copy_len_nonzero, clk, rst_n, state_reg != S_IDLE, len_reg != 5'd0)
    `RTFLZ_NEXT(a_last_returns_idle, clk, rst_n, emit.valid && emit.last, state_reg == S_IDLE)
    `RTFLZ_NEXT(a_finished_sticks, clk, rst_n, finished_reg, finished_reg)
    `RTFLZ_ASSERT(a_no_rw_same_cycle, clk, rst_n, !(win_req.rd_en && win_req.wr_en))

endmodule

[sv/rtf_lz_window_decompressor.sv]
// Top level of the compressed RTF (LZFU) payload decompressor.
//
// Channels: payload takes one compressed byte per item (flag, literal or
// reference byte); result gives one decompressed byte per item with run_last
// on the final byte caused by an input item and stream_done on the byte that
// reaches target_length; cfg writes target_length and is always ready.
// Steps: a flag byte or the first byte of a reference is taken in S_IDLE with
// no further step. A literal passes through S_EMIT. A reference second byte
// gives L output bytes (2..17): each copied byte needs a read step (S_READ) and
// an emit/write step (S_EMIT); the 4096-byte history window is never read and written at once.
// Once the target is reached, further payload bytes are taken and dropped.
// Reset: the window reads as the RTF preamble followed by zeros, the write
// pointer is 207, counts and parse state clear and target_length is 0; no
// clearing pass is needed, reset takes effect at once.
// Stall: one output register sits on result; the sequencer holds its emit
// step while that register is full and not taken, and payload is not ready
// until the current item has produced all its bytes.
`timescale 1ns / 1ps
module rtf_lz_window_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    rtflz_in_if.sink    payload,
    rtflz_out_if.source result,
    rtflz_cfg_if.sink   cfg
);
    import rtflz_pkg::*;

    emit_t      emit;
    win_req_t   win_req;
    logic [7:0] win_rdata;
    logic       slot_free;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       done_reg;

    assign slot_free = !out_valid_reg || result.ready;
    assign cfg.ready = 1'b1;

    rtflz_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (payload.valid),
        .in_byte   (payload.in_byte),
        .in_ready  (payload.ready),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.target_length),
        .slot_free (slot_free),
        .emit      (emit),
        .win_req   (win_req),
        .win_rdata (win_rdata)
    );

    rtflz_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (win_req),
        .rdata (win_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (slot_free)
            out_valid_reg <= emit.valid;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_byte_reg <= emit.data;
            run_last_reg <= emit.last;
            done_reg     <= emit.done;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.run_last    = run_last_reg;
    assign result.stream_done = done_reg;

endmodule

[bench/rtflz_stream_checker.sv]
// Checker: decodes the compressed payload on its own and compares every output byte.
`timescale 1ns / 1ps
module rtflz_stream_checker (
    input  logic   clk,
    input  logic   rst_n,
    rtflz_in_if    payload,
    rtflz_out_if   result,
    rtflz_cfg_if   cfg,
    output int     errors,
    output int     pending
);
    import rtflz_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } dec_byte_t;

    localparam logic [8*PREAMBLE_LENGTH-1:0] RTF_HEADER = {
        "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}{\\f0\\fnil \\froman ",
        "\\fswiss \\fmodern \\fscript \\fdecor MS Sans SerifSymbolArialTimes ",
        "New RomanCourier{\\colortbl\\red0\\green0\\blue0",
        8'h0D, 8'h0A,
        "\\par \\pard",
        "\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
    };

    logic [7:0]  hist [0:WINDOW_DEPTH-1];
    win_addr_t   put_at;
    logic [31:0] made_count;
    logic [31:0] target_len;
    logic [7:0]  flag_bits;
    logic [3:0]  tokens_left;
    logic [1:0]  phase;
    logic [7:0]  ref_hi;
    logic        done_flag;
    dec_byte_t   owed_bytes [$];

    task automatic put_byte(input logic [7:0] b, output logic hit);
        dec_byte_t r;
        hist[put_at] = b;
        put_at       = put_at + 1'b1;
        made_count   = made_count + 1;
        hit          = (made_count >= target_len);
        if (hit)
        begin
            done_flag = 1'b1;
        end
        r.out_byte    = b;
        r.run_last    = 1'b0;
        r.stream_done = hit;
        owed_bytes.push_back(r);
    endtask

    task automatic next_token();
        flag_bits   = flag_bits >> 1;
        tokens_left = (tokens_left == 4'd0) ? 4'd0 : tokens_left - 4'd1;
        phase       = (tokens_left == 4'd0) ? PH_FLAG : PH_TOKEN;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        win_addr_t src;
        int        run_len;
        logic      hit;
        int        first_idx;
        dec_byte_t tail;
        first_idx = owed_bytes.size();
        hit       = 1'b0;
        if (done_flag || made_count >= target_len)
        begin
            return;
        end
        case (phase)
            PH_TOKEN:
            begin
                if (!flag_bits[0])
                begin
                    put_byte(b, hit);
                    next_token();
                end
                else
                begin
                    ref_hi = b;
                    phase  = PH_REF;
                end
            end
            PH_REF:
            begin
                src     = {ref_hi, b[7:4]};
                run_len = int'(b[3:0]) + 2;
                while (run_len > 0 && !hit)
                begin
                    put_byte(hist[src], hit);
                    src     = src + 1'b1;
                    run_len = run_len - 1;
                end
                next_token();
            end
            default:
            begin
                flag_bits   = b;
                tokens_left = TOKENS_PER_FLAG;
                phase       = PH_TOKEN;
            end
        endcase
        if (owed_bytes.size() > first_idx)
        begin
            tail = owed_bytes.pop_back();
            tail.run_last = 1'b1;
            owed_bytes.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dec_byte_t want;
        int        bad;
        bad = 0;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                hist[i] = (i < PREAMBLE_LENGTH) ?
                          RTF_HEADER[8*(PREAMBLE_LENGTH-1-i) +: 8] : 8'h00;
            end
            put_at      = win_addr_t'(PREAMBLE_LENGTH);
            made_count  = '0;
            target_len  = '0;
            flag_bits   = '0;
            tokens_left = '0;
            phase       = PH_FLAG;
            ref_hi      = '0;
            done_flag   = 1'b0;
            owed_bytes.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // output first: a byte can never stem from the item taken at the same edge
            if (result.valid && result.ready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $error("out_byte: expected none, got %02h", result.out_byte);
                    bad++;
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, result.out_byte);
                        bad++;
                    end
                    if (result.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, result.run_last);
                        bad++;
                    end
                    if (result.stream_done !== want.stream_done)
                    begin
                        $error("stream_done: expected %0b, got %0b",
                               want.stream_done, result.stream_done);
                        bad++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                target_len = cfg.target_length;
            end
            if (payload.valid && payload.ready)
            begin
                decode_byte(payload.in_byte);
            end
            errors  <= errors + bad;
            pending <= owed_bytes.size();
        end
    end

endmodule

[bench/tb_rtf_lz_window_decompressor.sv]
// Testbench top: clock, reset, payload and target stimulus, output stalls, verdict.
`timescale 1ns / 1ps
module tb_rtf_lz_window_decompressor;
    import rtflz_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 40;

    logic clk = 1'b0;
    logic rst_n;

    rtflz_in_if  pay_if ();
    rtflz_out_if res_if ();
    rtflz_cfg_if cfg_if ();

    int          err_count;
    int          owed_count;
    int          stuck_cycles = 0;
    int unsigned burst_left;
    int unsigned produced;
    bit          squeeze_req = 1'b0;

    rtf_lz_window_decompressor DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (pay_if),
        .result  (res_if),
        .cfg     (cfg_if)
    );

    rtflz_stream_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (pay_if),
        .result  (res_if),
        .cfg     (cfg_if),
        .errors  (err_count),
        .pending (owed_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic feed_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                pay_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pay_if.valid   <= 1'b1;
        pay_if.in_byte <= b;
        do @(posedge clk); while (!pay_if.ready);
    endtask

    task automatic send_lit(input logic [7:0] b);
        feed_byte(b);
        produced++;
    endtask

    task automatic send_ref(input win_addr_t pos, input int len);
        feed_byte(pos[11:4]);
        feed_byte({pos[3:0], 4'(len - 2)});
        produced += len;
    endtask

    function automatic win_addr_t write_head();
        return win_addr_t'(PREAMBLE_LENGTH + produced);
    endfunction

    task automatic random_group();
        logic [7:0] flags;
        win_addr_t  pos;
        flags = 8'($urandom);
        feed_byte(flags);
        for (int k = 0; k < 8; k++)
        begin
            if (!flags[k])
            begin
                send_lit(8'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: pos = write_head() - win_addr_t'($urandom_range(0, 20));
                    1: pos = win_addr_t'($urandom_range(0, PREAMBLE_LENGTH - 1));
                    default: pos = win_addr_t'($urandom);
                endcase
                send_ref(pos, $urandom_range(2, 17));
            end
        end
    endtask

    task automatic settle();
        pay_if.valid <= 1'b0;
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_target(input logic [31:0] v);
        cfg_if.valid         <= 1'b1;
        cfg_if.target_length <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin : sink_side
        int mode;
        int stretch;
        bit squeezed;
        squeezed     = 1'b0;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                res_if.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(4, 64);
            repeat (stretch)
            begin
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= 1'($urandom_range(0, 1));
                    2: res_if.ready <= ($urandom_range(0, 7) == 0);
                    default: res_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pay_if.valid && pay_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
            begin
                stuck_cycles <= 0;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_rtf_lz_window_decompressor: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n                = 1'b0;
        pay_if.valid         = 1'b0;
        pay_if.in_byte       = 8'h00;
        cfg_if.valid         = 1'b0;
        cfg_if.target_length = 32'd0;
        burst_left           = 0;
        produced             = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero target: every item is dropped
        set_target(32'd0);
        repeat (6) feed_byte(8'($urandom));
        settle();

        set_target(32'hFFFF_FFFF);
        feed_byte(8'h00);
        send_lit(8'h00);
        send_lit(8'hFF);
        send_lit(8'h55);
        send_lit(8'hAA);
        send_lit(8'h01);
        send_lit(8'h80);
        send_lit(8'h7F);
        send_lit(8'hFE);
        feed_byte(8'hFF);
        send_ref(12'h000, 2);
        send_ref(12'hFFF, 17);            // wraps past the top of the window
        send_ref(12'd206, 3);             // last preamble byte
        send_ref(write_head(), 5);        // reads the entry about to be written
        send_ref(write_head() - 12'd2, 10);  // overlapping copy
        send_ref(12'd207, 8);
        send_ref(12'h800, 17);
        send_ref(12'h012, 14);

        for (int g = 0; g < 14; g++)
        begin
            if (g == 4)
            begin
                squeeze_req = 1'b1;
            end
            random_group();
        end
        settle();

        // target already met: dropped, stream stays open
        set_target(produced);
        repeat (4) feed_byte(8'($urandom));
        settle();
        set_target(32'd1);
        repeat (3) feed_byte(8'($urandom));
        settle();

        // copy cut short at the target
        set_target(produced + 5);
        feed_byte(8'hFF);
        send_ref(write_head() - 12'd3, 17);
        repeat (4) feed_byte(8'($urandom));
        settle();

        // finished stays set after a new target
        set_target(32'hFFFF_FFFF);
        repeat (5) feed_byte(8'($urandom));
        settle();

        if (err_count == 0)
        begin
            $display("tb_rtf_lz_window_decompressor: done, clean");
        end
        else
        begin
            $display("tb_rtf_lz_window_decompressor: done, errors");
        end
        $finish;
    end

endmodule

[rtf_lz_window_decompressor.f]
+incdir+sv
sv/rtflz_pkg.sv
sv/rtflz_ifs.sv
sv/rtflz_window.sv
sv/rtflz_seq.sv
sv/rtf_lz_window_decompressor.sv
bench/rtflz_stream_checker.sv
bench/tb_rtf_lz_window_decompressor.sv
